FILE: design/bids_pkg.sv
// Shared types, constants and helpers for the Bresenham image downscaler.
`default_nettype none

package bids_pkg;

	// Largest source or box dimension handled
	localparam int MAX_DIM = 1024;
	// Fraction bits of the compression ratio
	localparam int FRAC_W  = 10;
	// Dimension width (holds MAX_DIM itself)
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	// Index width (holds MAX_DIM - 1)
	localparam int IDX_W   = $clog2(MAX_DIM);
	// Dividend, divisor and quotient width of the ratio divider
	localparam int QW      = DIM_W + FRAC_W;
	// Divider step counter width
	localparam int CNT_W   = $clog2(QW);
	// Bresenham error term width, signed
	localparam int ERR_W   = DIM_W + 2;
	// Width of a configuration register
	localparam int CFG_W   = 11;
	// Pixel width
	localparam int PIX_W   = 8;
	// Output tdata width: pixel, column, row, padded to whole bytes
	localparam int OUT_RAW_W = PIX_W + 2 * IDX_W;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	// Unity ratio in fixed point
	localparam logic [QW-1:0] RATIO_ONE = QW'(1 << FRAC_W);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_BOX_WIDTH  = 2'd2,
		REG_BOX_HEIGHT = 2'd3
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_PREP,
		ST_FINISH
	} state_t;

	// The four divisions done at image start, in order
	typedef enum logic [1:0] {
		OP_RW = 2'd0,
		OP_RH = 2'd1,
		OP_DW = 2'd2,
		OP_DH = 2'd3
	} div_op_t;

	// Sequencer controls towards the datapath
	typedef struct packed {
		logic start;
		logic div_load;
		logic div_step;
		logic div_done;
		logic prep;
		logic finish;
	} seq_ctrl_t;

	// Source size: saturate at MAX_DIM
	function automatic logic [DIM_W-1:0] sat_src(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v > CFG_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	// Box size: zero reads as one, saturate at MAX_DIM
	function automatic logic [DIM_W-1:0] sat_box(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > CFG_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/bresenham_image_downscaler_top.sv
// Top level of the Bresenham nearest-sample image downscaler.
`default_nettype none

// Streams an 8-bit raster image in and forwards the nearest-sample subset that
// fits the configured box, keeping the aspect ratio. Set the four size
// registers while idle; they are latched by the pixel flagged as first of
// image. Its transfer latches the sizes, then the ratio and both output sizes
// come from four 21-bit divisions on one restoring divider that retires one
// quotient bit a cycle, each after its load step; then the error terms are set
// up and the pixel itself is handled, and the input is not ready until then.
// Every other pixel is handled as it is accepted, which waits while the output
// register is full and not being read. The output register lets a new pixel
// enter in the cycle that the previous result leaves. Pixels before an image
// start, or after the last pixel of an image, give no result.
module bresenham_image_downscaler_top
	import bids_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration write channel
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	// Source pixel stream
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [PIX_W-1:0]  s_axis_tdata,   // [7:0] pixel
	input  wire logic              s_axis_tuser,   // first_of_image
	// Downscaled pixel stream
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata,   // [7:0] pixel_out, [17:8] out_col,
	                                               // [27:18] out_row, zero above
	output logic                   m_axis_tlast    // last_of_image
);

	// Configuration registers
	logic [CFG_W-1:0] src_width_q, src_height_q, box_width_q, box_height_q;

	// Sequencer
	state_t    state_q, state_d;
	div_op_t   div_op_q;
	seq_ctrl_t ctrl;

	// Image setup
	logic [DIM_W-1:0] w_q, h_q, bw_q, bh_q;
	logic [DIM_W-1:0] dw_q, dh_q;
	logic [QW-1:0]    ratio_q;
	logic [IDX_W-1:0] w_m1_q, h_m1_q;
	logic [PIX_W-1:0] pix_q;
	logic             active_q, size_ok_q;

	// Bresenham state
	logic [IDX_W-1:0]        src_col_q, src_row_q, dst_col_q, dst_row_q;
	logic signed [ERR_W-1:0] col_err_q, row_err_q, col_init_q;
	logic signed [ERR_W-1:0] col_inc_fwd_q, col_inc_hold_q;
	logic signed [ERR_W-1:0] row_inc_fwd_q, row_inc_hold_q;

	// Divider
	logic [QW-1:0]    div_rem_q, div_quo_q, div_dvs_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic [QW:0]      div_rem_sh;
	logic             div_ge;
	logic [QW-1:0]    div_rem_next, div_quo_next;
	logic [QW-1:0]    div_dividend, div_divisor;

	// Output register
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pix_q;
	logic [IDX_W-1:0] out_col_q, out_row_q;
	logic             out_last_q;

	// Pixel handling
	logic             in_accept, out_free;
	logic             proc_en;
	logic [PIX_W-1:0] proc_pix;
	logic             col_last, row_last, col_fwd, row_fwd, emit;

	// Setup values
	logic signed [ERR_W-1:0] col_init_calc, row_init_calc;

	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= CFG_W'(1);
			src_height_q <= CFG_W'(1);
			box_width_q  <= CFG_W'(1);
			box_height_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				REG_BOX_WIDTH:  box_width_q  <= cfg_data;
				REG_BOX_HEIGHT: box_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and controls
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && s_axis_tuser) begin
					ctrl.start = 1'b1;
					state_d    = ST_DIV_LOAD;
				end
			end
			ST_DIV_LOAD: begin
				ctrl.div_load = 1'b1;
				state_d       = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				ctrl.div_step = 1'b1;
				if (div_cnt_q == CNT_W'(QW - 1)) begin
					ctrl.div_done = 1'b1;
					state_d       = (div_op_q == OP_DH) ? ST_PREP : ST_DIV_LOAD;
				end
			end
			ST_PREP: begin
				ctrl.prep = 1'b1;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				ctrl.finish = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Operands of the current division
	always_comb begin
		unique case (div_op_q)
			OP_RW: begin
				div_dividend = {w_q, FRAC_W'(0)};
				div_divisor  = QW'(bw_q);
			end
			OP_RH: begin
				div_dividend = {h_q, FRAC_W'(0)};
				div_divisor  = QW'(bh_q);
			end
			OP_DW: begin
				div_dividend = {w_q, FRAC_W'(0)};
				div_divisor  = ratio_q;
			end
			OP_DH: begin
				div_dividend = {h_q, FRAC_W'(0)};
				div_divisor  = ratio_q;
			end
			default: begin
				div_dividend = '0;
				div_divisor  = '0;
			end
		endcase
	end

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign div_rem_sh   = {div_rem_q, div_quo_q[QW-1]};
	assign div_ge       = div_rem_sh >= {1'b0, div_dvs_q};
	assign div_rem_next = div_ge ? QW'(div_rem_sh - {1'b0, div_dvs_q}) : div_rem_sh[QW-1:0];
	assign div_quo_next = {div_quo_q[QW-2:0], div_ge};

	// Divider and op counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_op_q <= OP_RW;
		end else if (ctrl.start) begin
			div_op_q <= OP_RW;
		end else if (ctrl.div_done && div_op_q != OP_DH) begin
			div_op_q <= div_op_t'(div_op_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.div_load) begin
			div_rem_q <= '0;
			div_quo_q <= div_dividend;
			div_dvs_q <= div_divisor;
			div_cnt_q <= '0;
		end else if (ctrl.div_step) begin
			div_rem_q <= div_rem_next;
			div_quo_q <= div_quo_next;
			div_cnt_q <= div_cnt_q + CNT_W'(1);
		end
	end

	// Latch image sizes and collect the division results
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			w_q   <= sat_src(src_width_q);
			h_q   <= sat_src(src_height_q);
			bw_q  <= sat_box(box_width_q);
			bh_q  <= sat_box(box_height_q);
			pix_q <= s_axis_tdata;
		end
		if (ctrl.div_done) begin
			unique case (div_op_q)
				OP_RW: ratio_q <= (div_quo_next < RATIO_ONE) ? RATIO_ONE : div_quo_next;
				OP_RH: if (div_quo_next > ratio_q) ratio_q <= div_quo_next;
				OP_DW: dw_q <= div_quo_next[DIM_W-1:0];
				OP_DH: dh_q <= div_quo_next[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Initial error terms: 2*(dst-1) - (src-1)
	assign col_init_calc = ERR_W'({dw_q, 1'b0}) - ERR_W'(w_q) - ERR_W'(1);
	assign row_init_calc = ERR_W'({dh_q, 1'b0}) - ERR_W'(h_q) - ERR_W'(1);

	// Pixel to handle this cycle: a plain pixel from the stream, or the held
	// first pixel once setup is done
	assign proc_en  = (in_accept && !s_axis_tuser) || ctrl.finish;
	assign proc_pix = ctrl.finish ? pix_q : s_axis_tdata;

	// Sample selection
	assign col_last = src_col_q == w_m1_q;
	assign row_last = src_row_q == h_m1_q;
	assign col_fwd  = col_last || (!col_err_q[ERR_W-1] && col_err_q != '0);
	assign row_fwd  = row_last || (!row_err_q[ERR_W-1] && row_err_q != '0);
	assign emit     = proc_en && active_q && size_ok_q && col_fwd && row_fwd;

	// Setup and Bresenham stepping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ctrl.prep) begin
			active_q <= (w_q != '0) && (h_q != '0);
		end else if (proc_en && active_q && col_last && row_last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.prep) begin
			size_ok_q      <= (dw_q != '0) && (dh_q != '0);
			w_m1_q         <= IDX_W'(w_q - DIM_W'(1));
			h_m1_q         <= IDX_W'(h_q - DIM_W'(1));
			src_col_q      <= '0;
			src_row_q      <= '0;
			dst_col_q      <= '0;
			dst_row_q      <= '0;
			col_init_q     <= col_init_calc;
			col_err_q      <= col_init_calc;
			row_err_q      <= row_init_calc;
			col_inc_fwd_q  <= ERR_W'({dw_q, 1'b0}) - ERR_W'({w_q, 1'b0});
			col_inc_hold_q <= ERR_W'({dw_q, 1'b0}) - ERR_W'(2);
			row_inc_fwd_q  <= ERR_W'({dh_q, 1'b0}) - ERR_W'({h_q, 1'b0});
			row_inc_hold_q <= ERR_W'({dh_q, 1'b0}) - ERR_W'(2);
		end else if (proc_en && active_q) begin
			if (col_last) begin
				// End of a source row: step the row term, restart the column term
				if (!row_err_q[ERR_W-1] && row_err_q != '0) begin
					dst_row_q <= dst_row_q + IDX_W'(1);
					row_err_q <= row_err_q + row_inc_fwd_q;
				end else begin
					row_err_q <= row_err_q + row_inc_hold_q;
				end
				src_row_q <= src_row_q + IDX_W'(1);
				src_col_q <= '0;
				dst_col_q <= '0;
				col_err_q <= col_init_q;
			end else begin
				if (!col_err_q[ERR_W-1] && col_err_q != '0) begin
					dst_col_q <= dst_col_q + IDX_W'(1);
					col_err_q <= col_err_q + col_inc_fwd_q;
				end else begin
					col_err_q <= col_err_q + col_inc_hold_q;
				end
				src_col_q <= src_col_q + IDX_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pix_q  <= proc_pix;
			out_col_q  <= dst_col_q;
			out_row_q  <= dst_row_q;
			out_last_q <= col_last && row_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_row_q, out_col_q, out_pix_q});
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the Bresenham nearest-sample image downscaler.
`timescale 1ns / 100ps

module tb_top;
	import bids_pkg::*;

	// One downscaled pixel as the block should deliver it
	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
		logic             last;
	} sample_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [PIX_W-1:0]  s_axis_tdata;   // [7:0] pixel
	logic              s_axis_tuser;   // first_of_image
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;   // [7:0] pixel_out, [17:8] out_col, [27:18] out_row
	logic              m_axis_tlast;   // last_of_image

	// Shadow copy of the size registers and of the scaler state
	logic [CFG_W-1:0] size_regs [4];
	int unsigned      img_w, img_h, ratio_fx, out_w, out_h;
	int unsigned      col_pos, row_pos, out_col_pos, out_row_pos;
	int               col_err, row_err;
	bit               in_image;

	sample_t expected_samples [$];
	int      error_count;
	int      gap_pct;
	int      stall_pct;

	bresenham_image_downscaler_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#2000000;
		$display("bresenham_image_downscaler_top regression: fail");
		$finish;
	end

	// Source sizes saturate; box sizes also read zero as one
	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input bit is_box);
		if (is_box && v == '0) begin
			return 1;
		end
		if (v > MAX_DIM) begin
			return MAX_DIM;
		end
		return v;
	endfunction

	function automatic int col_err_init();
		return 2 * (int'(out_w) - 1) - (int'(img_w) - 1);
	endfunction

	// Latch sizes, form the ratio and output sizes, load the error terms
	task automatic start_image();
		int unsigned bw, bh, rw, rh;
		bw = clamp_dim(size_regs[REG_BOX_WIDTH], 1'b1);
		bh = clamp_dim(size_regs[REG_BOX_HEIGHT], 1'b1);
		img_w = clamp_dim(size_regs[REG_SRC_WIDTH], 1'b0);
		img_h = clamp_dim(size_regs[REG_SRC_HEIGHT], 1'b0);
		rw = (img_w << FRAC_W) / bw;
		rh = (img_h << FRAC_W) / bh;
		if (rw < (1 << FRAC_W)) rw = 1 << FRAC_W;
		if (rh < (1 << FRAC_W)) rh = 1 << FRAC_W;
		ratio_fx = (rw > rh) ? rw : rh;
		out_w = (img_w << FRAC_W) / ratio_fx;
		out_h = (img_h << FRAC_W) / ratio_fx;
		col_pos = 0;
		row_pos = 0;
		out_col_pos = 0;
		out_row_pos = 0;
		col_err = col_err_init();
		row_err = 2 * (int'(out_h) - 1) - (int'(img_h) - 1);
		in_image = (img_w != 0) && (img_h != 0);
	endtask

	// Advance the scaler by one source pixel, queueing the sample it selects
	task automatic select_sample(input logic [PIX_W-1:0] pix, input bit first);
		bit      col_last, row_last, col_hit, row_hit;
		sample_t s;
		if (first) start_image();
		if (!in_image) return;
		col_last = (col_pos == img_w - 1);
		row_last = (row_pos == img_h - 1);
		col_hit = col_last || (col_err > 0);
		row_hit = row_last || (row_err > 0);
		if (out_w != 0 && out_h != 0 && col_hit && row_hit) begin
			s.pixel = pix;
			s.col = out_col_pos[IDX_W-1:0];
			s.row = out_row_pos[IDX_W-1:0];
			s.last = col_last && row_last;
			expected_samples.push_back(s);
		end
		if (col_last) begin
			if (row_err > 0) begin
				out_row_pos++;
				row_err += 2 * ((int'(out_h) - 1) - (int'(img_h) - 1));
			end else begin
				row_err += 2 * (int'(out_h) - 1);
			end
			if (row_last) in_image = 1'b0;
			row_pos++;
			col_pos = 0;
			out_col_pos = 0;
			col_err = col_err_init();
		end else begin
			if (col_err > 0) begin
				out_col_pos++;
				col_err += 2 * ((int'(out_w) - 1) - (int'(img_w) - 1));
			end else begin
				col_err += 2 * (int'(out_w) - 1);
			end
			col_pos++;
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Output side: random stalls, every transfer checked against the oldest sample
	always @(posedge clk) begin : collect
		sample_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_samples.size() == 0) begin
				$error("unexpected transfer: pixel_out %0d, out_col %0d, out_row %0d",
					m_axis_tdata[PIX_W-1:0], m_axis_tdata[PIX_W +: IDX_W],
					m_axis_tdata[PIX_W+IDX_W +: IDX_W]);
				error_count++;
			end else begin
				want = expected_samples.pop_front();
				check_field("pixel_out", want.pixel, m_axis_tdata[PIX_W-1:0]);
				check_field("out_col", want.col, m_axis_tdata[PIX_W +: IDX_W]);
				check_field("out_row", want.row, m_axis_tdata[PIX_W+IDX_W +: IDX_W]);
				check_field("last_of_image", want.last, m_axis_tlast);
				check_field("tdata padding", 0, m_axis_tdata[OUT_W-1:OUT_RAW_W]);
			end
		end
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// One source pixel transfer, with an optional idle gap in front
	task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit first);
		int gap;
		gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		s_axis_tuser <= first;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		select_sample(pix, first);
	endtask

	task automatic send_image(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			send_pixel(PIX_W'($urandom_range(255)), k == 0);
		end
	endtask

	// Hold the stream until every sample is back and the block has gone quiet
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	// Write all four size registers back to back; only called while idle
	task automatic write_sizes(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
			input logic [CFG_W-1:0] bw, input logic [CFG_W-1:0] bh);
		logic [CFG_W-1:0] vals [4];
		reg_idx_t         ri;
		vals[REG_SRC_WIDTH] = sw;
		vals[REG_SRC_HEIGHT] = sh;
		vals[REG_BOX_WIDTH] = bw;
		vals[REG_BOX_HEIGHT] = bh;
		ri = REG_SRC_WIDTH;
		repeat (4) begin
			cfg_valid <= 1'b1;
			cfg_index <= ri;
			cfg_data <= vals[ri];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			size_regs[ri] = vals[ri];
			ri = ri.next();
		end
		cfg_valid <= 1'b0;
	endtask

	// Pixels before any image and after the last one are dropped; 1x1 into 1x1 at reset sizes
	task automatic test_stray_and_unit_image();
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'hA5, 1'b1);
		send_pixel(8'h5A, 1'b0);
		wait_drained();
	endtask

	// Zero source width gives an empty image; a tall thin source gives zero output width
	task automatic test_empty_and_zero_output();
		write_sizes(11'd0, 11'd3, 11'd4, 11'd4);
		send_image(2);
		wait_drained();
		write_sizes(11'd1, 11'd1024, 11'd0, 11'd1);
		send_image(3);
		wait_drained();
	endtask

	// Oversized source and box saturate; a new image start cuts the old one short
	task automatic test_saturation_and_restart();
		write_sizes(11'd2047, 11'd1, 11'd2047, 11'd1024);
		send_image(5);
		send_image(3);
		wait_drained();
		write_sizes(11'd3, 11'd2, 11'd2, 11'd1);
		send_image(6);
		wait_drained();
	endtask

	function automatic logic [CFG_W-1:0] pick_dim(input bit is_box);
		logic [CFG_W-1:0] extremes [6];
		extremes = '{11'd0, 11'd1, 11'd1023, 11'd1024, 11'd1025, 11'd2047};
		if ($urandom_range(15) == 0) begin
			return extremes[$urandom_range(5)];
		end
		if (!is_box && $urandom_range(24) == 0) begin
			return '0;
		end
		return CFG_W'($urandom_range(is_box ? 0 : 1, 12));
	endfunction

	// Random images, mostly small and complete, some cut short or followed by stray pixels
	task automatic test_random_images(input int gap, input int stall, input int quota);
		int               items, npix, count, mode;
		logic [CFG_W-1:0] sw, sh, bw, bh;
		gap_pct = gap;
		stall_pct = stall;
		items = 0;
		while (items < quota) begin
			sw = pick_dim(1'b0);
			sh = pick_dim(1'b0);
			bw = pick_dim(1'b1);
			bh = pick_dim(1'b1);
			write_sizes(sw, sh, bw, bh);
			npix = clamp_dim(sw, 1'b0) * clamp_dim(sh, 1'b0);
			repeat ($urandom_range(1, 3)) begin
				mode = $urandom_range(9);
				if (npix == 0) begin
					count = $urandom_range(1, 3);
				end else if (npix > 150 || mode == 0) begin
					count = $urandom_range(1, (npix < 40) ? npix : 40);
				end else begin
					count = npix;
				end
				// Keep the phase close to its share of the items
				if (count > quota - items) begin
					count = quota - items;
				end
				send_image(count);
				items += count;
				if (mode == 1 && count != 0 && count == npix) begin
					repeat ($urandom_range(1, 2)) send_pixel(PIX_W'($urandom_range(255)), 1'b0);
				end
			end
			wait_drained();
		end
	endtask

	initial begin
		cfg_valid = 1'b0;
		cfg_index = REG_SRC_WIDTH;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		arst_n = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		error_count = 0;
		in_image = 1'b0;
		for (int i = 0; i < 4; i++) size_regs[i] = 11'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stray_and_unit_image();
		test_empty_and_zero_output();
		test_saturation_and_restart();
		test_random_images(0, 0, 255);
		test_random_images(53, 0, 255);
		test_random_images(0, 53, 255);
		test_random_images(25, 25, 255);

		wait_drained();
		if (error_count == 0) begin
			$display("bresenham_image_downscaler_top regression: pass");
		end else begin
			$display("bresenham_image_downscaler_top regression: fail");
		end
		$finish;
	end

endmodule
